// ===== hw/rtl/text_line_filter_caret_notation_macros.svh =====
// Assertion macros shared by the checker of the text line filter.
// Clock aclk and active-low reset aresetn must be in scope where they are used.
`ifndef TEXT_LINE_FILTER_CARET_NOTATION_MACROS_SVH
`define TEXT_LINE_FILTER_CARET_NOTATION_MACROS_SVH

// Property checked on every clock edge outside reset
`define TLF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Property checked on every clock edge, reset included
`define TLF_ASSERT_NR(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== hw/rtl/tlf_pkg.sv =====
// Shared types and constants of the text line filter.
// No dependencies; imported by every module of the block except tlf_queue.
`timescale 1ns / 1ps
`default_nettype none

package tlf_pkg;

    // Configuration port widths and register indexes
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_NUMBER_MODE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SQUEEZE_ON       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TABS_VISIBLE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NONPRINT_VISIBLE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ENDS_VISIBLE     = 3'd4;

    // Numbering modes
    localparam logic [1:0] NUM_ALL      = 2'd1;
    localparam logic [1:0] NUM_NONBLANK = 2'd2;

    // Byte codes
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_I      = 8'h49;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_DEL    = 8'h7F;

    typedef struct packed {
        logic [1:0] number_mode;
        logic       squeeze_on;
        logic       tabs_visible;
        logic       nonprint_visible;
        logic       ends_visible;
    } tlf_cfg_t;

    // One queued job: optional number prefix, then one to four literal bytes
    typedef struct packed {
        logic            num;
        logic [1:0]      chr_last;
        logic [3:0][7:0] chr_bytes;
    } tlf_job_t;

endpackage

`default_nettype wire

// ===== hw/rtl/text_line_filter_caret_notation.sv =====
// Text line filter with line numbers, blank-line squeeze and caret notation.
// Top level; uses tlf_pkg, tlf_front, tlf_queue and tlf_back.
//
// Usage:
//   Input channel s_*: one raw text byte per item, s_file_begin marks the
//   first byte of a new file. Output channel m_*: formatted bytes, with
//   m_last_out set on the last byte that an input item causes. A squeezed
//   blank line causes no output at all.
//   Configuration: cfg_wr_en writes cfg_wdata into register cfg_index
//   (0 number_mode, 1 squeeze_on, 2 tabs_visible, 3 nonprint_visible,
//   4 ends_visible); write only while the block is idle.
//   Flow: an accepted item goes into the job queue and its first output
//   byte then into the output register. While m_ready is high the back end
//   emits one byte per cycle, so plain bytes pass at one item per cycle; an
//   item of n bytes (up to COUNT_DIGITS + 5) holds the back end until all
//   are sent, and the two-entry job queue fills and stalls the input.
//   Reset: clears configuration, sets line start, clears the blank run and
//   the line counter; no clearing pass, ready once reset is released.
//   Stall: while m_ready is low the output byte holds and the queue absorbs
//   up to two more items before s_ready drops.
`timescale 1ns / 1ps
`default_nettype none

module text_line_filter_caret_notation import tlf_pkg::*; #(
    parameter int COUNT_DIGITS = 8
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [7:0]            s_in_byte,
    input  wire logic                  s_file_begin,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [7:0]                 m_out_byte,
    output logic                       m_last_out
);

    localparam int DIG_W = COUNT_DIGITS * 4;
    localparam int JOB_W = $bits(tlf_job_t);
    localparam int QW    = JOB_W + DIG_W;

    tlf_cfg_t         cfg_reg, cfg_next;
    logic             q_full;
    logic             push;
    tlf_job_t         push_job;
    logic [DIG_W-1:0] push_digits;
    logic             pop;
    logic             head_valid;
    logic [QW-1:0]    head_word;
    tlf_job_t         head_job;
    logic [DIG_W-1:0] head_digits;

    // Decode configuration writes; unknown indexes are dropped
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_NUMBER_MODE:      cfg_next.number_mode      = cfg_wdata;
                REG_SQUEEZE_ON:       cfg_next.squeeze_on       = cfg_wdata[0];
                REG_TABS_VISIBLE:     cfg_next.tabs_visible     = cfg_wdata[0];
                REG_NONPRINT_VISIBLE: cfg_next.nonprint_visible = cfg_wdata[0];
                REG_ENDS_VISIBLE:     cfg_next.ends_visible     = cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    tlf_front #(
        .COUNT_DIGITS (COUNT_DIGITS)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_in_byte    (s_in_byte),
        .s_file_begin (s_file_begin),
        .q_full       (q_full),
        .push         (push),
        .push_job     (push_job),
        .push_digits  (push_digits)
    );

    tlf_queue #(
        .WIDTH (QW),
        .DEPTH (2)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_data  ({push_digits, push_job}),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head_data  (head_word)
    );

    assign head_job    = head_word[JOB_W-1:0];
    assign head_digits = head_word[QW-1:JOB_W];

    tlf_back #(
        .COUNT_DIGITS (COUNT_DIGITS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .head_valid  (head_valid),
        .head_job    (head_job),
        .head_digits (head_digits),
        .pop         (pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_last_out  (m_last_out)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/tlf_front.sv =====
// Front end of the text line filter: accepts items, tracks line state and
// the line counter, and turns each item into a job. Depends on tlf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tlf_front import tlf_pkg::*; #(
    parameter int COUNT_DIGITS = 8
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire tlf_cfg_t                  cfg,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic [7:0]                s_in_byte,
    input  wire logic                      s_file_begin,
    input  wire logic                      q_full,
    output logic                           push,
    output tlf_job_t                       push_job,
    output logic [COUNT_DIGITS*4-1:0]      push_digits
);

    logic                      at_line_start_reg, at_line_start_next;
    logic [1:0]                blank_run_reg, blank_run_next;
    logic [COUNT_DIGITS*4-1:0] digits_reg, digits_next;

    logic                      accept;
    logic                      als;
    logic [1:0]                br;
    logic [1:0]                br_inc;
    logic                      drop;
    logic                      num;
    logic [COUNT_DIGITS*4-1:0] digits_inc;
    logic                      carry;
    logic [7:0]                low;
    logic [7:0]                p0;
    logic [7:0]                p1;
    logic                      p_two;
    logic [3:0][7:0]           bytes;
    logic [1:0]                last;

    assign s_ready = !q_full;
    assign accept  = s_valid && !q_full;

    // Increment the decimal counter, least significant digit first
    always_comb begin
        carry = 1'b1;
        for (int i = 0; i < COUNT_DIGITS; i++) begin
            digits_inc[i*4 +: 4] = digits_reg[i*4 +: 4];
            if (carry) begin
                digits_inc[i*4 +: 4] = (digits_reg[i*4 +: 4] >= 4'd9) ? 4'd0
                                      : digits_reg[i*4 +: 4] + 4'd1;
            end
            carry = carry && (digits_reg[i*4 +: 4] >= 4'd9);
        end
    end

    // Notation of the low seven bits of a nonprinting byte
    always_comb begin
        low   = {1'b0, s_in_byte[6:0]};
        p0    = low;
        p1    = CH_QMARK;
        p_two = 1'b0;
        if (low < CH_SPACE) begin
            p0    = CH_CARET;
            p1    = low + CH_AT;
            p_two = 1'b1;
        end else if (low == CH_DEL) begin
            p0    = CH_CARET;
            p1    = CH_QMARK;
            p_two = 1'b1;
        end
    end

    // Classify the item and build its job
    always_comb begin
        als                = s_file_begin ? 1'b1 : at_line_start_reg;
        br                 = s_file_begin ? 2'd0 : blank_run_reg;
        br_inc             = (br == 2'd3) ? 2'd3 : br + 2'd1;
        at_line_start_next = at_line_start_reg;
        blank_run_next     = blank_run_reg;
        drop               = 1'b0;
        num                = 1'b0;
        bytes              = '0;
        last               = 2'd0;

        if (s_in_byte == CH_NL) begin
            at_line_start_next = 1'b1;
            blank_run_next     = br;
            if (als) begin
                blank_run_next = br_inc;
                if (cfg.squeeze_on && br_inc > 2'd1) begin
                    drop = 1'b1;
                end else begin
                    num = (cfg.number_mode == NUM_ALL);
                end
            end
            if (cfg.ends_visible) begin
                bytes[0] = CH_DOLLAR;
                bytes[1] = CH_NL;
                last     = 2'd1;
            end else begin
                bytes[0] = CH_NL;
            end
        end else begin
            at_line_start_next = 1'b0;
            blank_run_next     = br;
            if (als) begin
                blank_run_next = 2'd0;
                num = (cfg.number_mode == NUM_ALL) || (cfg.number_mode == NUM_NONBLANK);
            end
            if (s_in_byte == CH_TAB && cfg.tabs_visible) begin
                bytes[0] = CH_CARET;
                bytes[1] = CH_I;
                last     = 2'd1;
            end else if (!cfg.nonprint_visible || s_in_byte == CH_TAB ||
                         (s_in_byte >= CH_SPACE && s_in_byte < CH_DEL)) begin
                bytes[0] = s_in_byte;
            end else if (s_in_byte[7]) begin
                bytes[0] = CH_M;
                bytes[1] = CH_DASH;
                bytes[2] = p0;
                bytes[3] = p1;
                last     = p_two ? 2'd3 : 2'd2;
            end else begin
                bytes[0] = p0;
                bytes[1] = p1;
                last     = p_two ? 2'd1 : 2'd0;
            end
        end

        digits_next = num ? digits_inc : digits_reg;
    end

    assign push               = accept && !drop;
    assign push_job.num       = num;
    assign push_job.chr_last  = last;
    assign push_job.chr_bytes = bytes;
    assign push_digits        = digits_next;

    // Hold line state; advance it on each accepted item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            at_line_start_reg <= 1'b1;
            blank_run_reg     <= 2'd0;
            digits_reg        <= '0;
        end else if (accept) begin
            at_line_start_reg <= at_line_start_next;
            blank_run_reg     <= blank_run_next;
            digits_reg        <= digits_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/tlf_queue.sv =====
// Short job queue between front and back of the text line filter.
// Register based, one push and one pop per cycle. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module tlf_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    input  wire logic             pop,
    output logic                  full,
    output logic                  head_valid,
    output logic [WIDTH-1:0]      head_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Advance pointers with wrap at the depth
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CW'(1);
        end else if (!do_push && do_pop) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store entries; payload needs no reset
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/tlf_back.sv =====
// Back end of the text line filter: walks the queue head job and, unless
// stalled, sends one byte per cycle via an output register. Uses tlf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tlf_back import tlf_pkg::*; #(
    parameter int COUNT_DIGITS = 8
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      head_valid,
    input  wire tlf_job_t                  head_job,
    input  wire logic [COUNT_DIGITS*4-1:0] head_digits,
    output logic                           pop,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic [7:0]                     m_out_byte,
    output logic                           m_last_out
);

    localparam int DW = $clog2(COUNT_DIGITS);
    localparam int KW = $clog2(COUNT_DIGITS + 6);

    logic          m_valid_reg, m_valid_next;
    logic [7:0]    out_byte_reg, out_byte_next;
    logic          last_reg, last_next;
    logic [KW-1:0] k_reg, k_next;

    logic [DW-1:0] hi;
    logic [KW-1:0] hi_ext;
    logic [KW-1:0] width_v;
    logic [KW-1:0] num_len;
    logic [KW-1:0] col;
    logic [KW-1:0] j;
    logic [1:0]    sel;
    logic          load;
    logic [7:0]    gen_byte;
    logic          gen_last;

    // Find the top nonzero digit of the counter snapshot
    always_comb begin
        hi = '0;
        for (int i = 0; i < COUNT_DIGITS; i++) begin
            if (head_digits[i*4 +: 4] != 4'd0) begin
                hi = DW'(i);
            end
        end
    end

    // Pick the byte at step k of the job
    always_comb begin
        hi_ext   = KW'(hi);
        width_v  = (hi_ext >= KW'(6)) ? hi_ext + KW'(1) : KW'(6);
        num_len  = head_job.num ? width_v + KW'(1) : '0;
        col      = width_v - KW'(1) - k_reg;
        j        = k_reg - num_len;
        sel      = j[1:0];
        gen_byte = head_job.chr_bytes[sel];
        gen_last = (sel == head_job.chr_last);
        if (k_reg < num_len) begin
            gen_last = 1'b0;
            if (k_reg == width_v) begin
                gen_byte = CH_TAB;
            end else if (col > hi_ext) begin
                gen_byte = CH_SPACE;
            end else begin
                gen_byte = CH_ZERO | {4'd0, head_digits[col[DW-1:0]*4 +: 4]};
            end
        end
    end

    assign load = head_valid && (!m_valid_reg || m_ready);
    assign pop  = load && gen_last;

    // Load the output register from the head job whenever it is free or being drained
    always_comb begin
        m_valid_next  = m_valid_reg;
        out_byte_next = out_byte_reg;
        last_next     = last_reg;
        k_next        = k_reg;
        if (load) begin
            m_valid_next  = 1'b1;
            out_byte_next = gen_byte;
            last_next     = gen_last;
            k_next        = gen_last ? '0 : k_reg + KW'(1);
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            k_reg       <= '0;
        end else begin
            m_valid_reg <= m_valid_next;
            k_reg       <= k_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_byte_reg <= out_byte_next;
        last_reg     <= last_next;
    end

    assign m_valid    = m_valid_reg;
    assign m_out_byte = out_byte_reg;
    assign m_last_out = last_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/tlf_checker.sv =====
// Port-level checker of the text line filter, bound to the top level.
// Depends on tlf_pkg and text_line_filter_caret_notation_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "text_line_filter_caret_notation_macros.svh"

module tlf_checker import tlf_pkg::*; (
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  s_valid,
    input wire logic                  s_ready,
    input wire logic [7:0]            s_in_byte,
    input wire logic                  s_file_begin,
    input wire logic                  m_valid,
    input wire logic                  m_ready,
    input wire logic [7:0]            m_out_byte,
    input wire logic                  m_last_out
);

    // A waiting input item holds
    `TLF_ASSERT(a_in_hold, s_valid && !s_ready |=> s_valid && $stable(s_in_byte) && $stable(s_file_begin), "input changed while waiting")

    // A stalled output byte holds
    `TLF_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_out_byte) && $stable(m_last_out), "output changed while stalled")

    // Out of reset: nothing to send, room to accept
    `TLF_ASSERT_NR(a_reset_state, !aresetn |=> !m_valid && s_ready, "bad state after reset")

    // A newline always closes the output of its item
    `TLF_ASSERT(a_newline_last, m_valid && m_out_byte == CH_NL |-> m_last_out, "newline not last")

    // An M that is not last opens M- notation, and the dash follows at once
    `TLF_ASSERT(a_meta_dash, m_valid && m_ready && m_out_byte == CH_M && !m_last_out |=> m_valid && m_out_byte == CH_DASH, "M- prefix broken")

endmodule

bind text_line_filter_caret_notation tlf_checker u_tlf_checker (.*);

`default_nettype wire
